[rtl/imlat_pkg.sv]
// ---------------------------------------------------------------------------
// imlat_pkg
// Shared widths, action codes and register indexes of the Ising lattice core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imlat_pkg;

	localparam int ACTION_W   = 2;
	localparam int SITE_W     = 4;
	localparam int DRAW_W     = 32;
	localparam int DE_W       = 5;
	localparam int SUM_W      = 10;
	localparam int ENERGY_W   = 11;
	localparam int CORR_W     = 10;
	localparam int DIST_W     = 4;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam int SIDE_DEFAULT = 16;

	localparam logic [ACTION_W-1:0] ACT_FLIP    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_MEASURE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_INIT    = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_THR_FOUR  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_THR_EIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CORR_DIST = 2'd2;

	localparam logic [DIST_W-1:0] CORR_DIST_RESET = 4'd5;

endpackage

`default_nettype wire

[rtl/imlat_if.sv]
// ---------------------------------------------------------------------------
// imlat channel interfaces
// Request, result and register write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface imlat_req_if
	import imlat_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [SITE_W-1:0]   site_row;
	logic [SITE_W-1:0]   site_col;
	logic [DRAW_W-1:0]   uniform_draw;

	modport source (output valid, action, site_row, site_col, uniform_draw, input ready);
	modport sink   (input valid, action, site_row, site_col, uniform_draw, output ready);
endinterface

interface imlat_rsp_if
	import imlat_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic                       flipped;
	logic signed [DE_W-1:0]     delta_energy;
	logic signed [SUM_W-1:0]    spin_sum;
	logic signed [ENERGY_W-1:0] lattice_energy;
	logic signed [CORR_W-1:0]   correlation_sum;

	modport source (output valid, flipped, delta_energy, spin_sum, lattice_energy,
		correlation_sum, input ready);
	modport sink   (input valid, flipped, delta_energy, spin_sum, lattice_energy,
		correlation_sum, output ready);
endinterface

interface imlat_cfg_if
	import imlat_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[rtl/imlat_ram.sv]
// ---------------------------------------------------------------------------
// imlat_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imlat_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/ising_metropolis_lattice_core.sv]
// ---------------------------------------------------------------------------
// ising_metropolis_lattice_core
// Metropolis flip engine over a SIDE x SIDE periodic lattice of +1/-1 spins.
// ---------------------------------------------------------------------------
// All spins live in one 1-bit lattice RAM with one read and one write port, and
// every flip and measure walks that RAM one read per cycle into its accumulators.
// A flip attempt reads the site and its four neighbours (5 reads), waits in
// ST_DRAIN for the last read, decides and writes back in ST_DECIDE, and then
// shows its result from ST_DONE; it takes no new item until it is back in
// ST_IDLE. A measure reads 4 spins per site. An init, and the clearing pass
// that follows reset, write one site per cycle over all SIDE*SIDE sites (256
// at the default size), during which no item is accepted. A result waits in
// an output register; the block finishes its next item only once that
// register is free. Register writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_lattice_core
	import imlat_pkg::*;
#(
	parameter int SIDE = SIDE_DEFAULT
) (
	input wire logic   clk,
	input wire logic   arst_n,
	imlat_req_if.sink  req,
	imlat_rsp_if.source rsp,
	imlat_cfg_if.sink  cfg
);

	localparam int IDX_W  = $clog2(SIDE);
	localparam int ADDR_W = $clog2(SIDE * SIDE);
	localparam int MOD_W  = ((IDX_W > SITE_W) ? IDX_W : SITE_W) + 1;

	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SIDE - 1);
	localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(SIDE);

	// read steps; flip: self, down, up, right, left; measure: self, right, down, dist
	localparam logic [2:0] STEP_SELF = 3'd0;
	localparam logic [2:0] STEP_NB1  = 3'd1;
	localparam logic [2:0] STEP_NB2  = 3'd2;
	localparam logic [2:0] STEP_NB3  = 3'd3;
	localparam logic [2:0] STEP_NB4  = 3'd4;

	localparam logic signed [DE_W-1:0] DE_FOUR = 5'sd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DECIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] step;
	} rd_tag_t;

	function automatic logic [IDX_W-1:0] mod_side(input logic [SITE_W-1:0] v);
		logic [MOD_W-1:0] x;
		x = MOD_W'(v);
		for (int i = 0; i < 4; i++) begin
			if (x >= MOD_W'(SIDE)) begin
				x = x - MOD_W'(SIDE);
			end
		end
		return IDX_W'(x);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
		return (v == IDX_LAST) ? '0 : v + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v);
		return (v == '0) ? IDX_LAST : v - IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W + 1)'(SIDE)) begin
			s = s - (IDX_W + 1)'(SIDE);
		end
		return IDX_W'(s);
	endfunction

	state_t                state_q;
	logic [ACTION_W-1:0]   act_q;
	logic                  init_q;
	logic [IDX_W-1:0]      row_q;
	logic [IDX_W-1:0]      col_q;
	logic [IDX_W-1:0]      dist_q;
	logic [2:0]            step_q;
	logic [DRAW_W-1:0]     draw_q;
	rd_tag_t               tag_s1;

	logic [DRAW_W-1:0]     thr_four_q;
	logic [DRAW_W-1:0]     thr_eight_q;
	logic [DIST_W-1:0]     corr_dist_q;

	logic                  s_q;
	logic signed [3:0]     nb_q;
	logic                  flip_q;
	logic [DE_W-1:0]       de_q;
	logic [SUM_W-1:0]      sum_q;
	logic [ENERGY_W-1:0]   energy_q;
	logic [CORR_W-1:0]     corr_q;

	logic                  out_valid_q;
	logic                  out_flipped_q;
	logic [DE_W-1:0]       out_de_q;
	logic [SUM_W-1:0]      out_sum_q;
	logic [ENERGY_W-1:0]   out_energy_q;
	logic [CORR_W-1:0]     out_corr_q;

	logic                  req_fire;
	logic                  slot_free;
	logic                  sweep_last;
	logic [2:0]            step_last;
	logic [IDX_W-1:0]      rd_row;
	logic [IDX_W-1:0]      rd_col;
	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	logic                  ram_we;
	logic                  ram_wdata;
	logic                  ram_rdata;
	logic                  same_spin;
	logic signed [DE_W-1:0] de_c;
	logic                  flip_c;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign cfg.ready  = 1'b1;
	assign slot_free  = !out_valid_q || rsp.ready;
	assign sweep_last = (row_q == IDX_LAST) && (col_q == IDX_LAST);
	assign step_last  = (act_q == ACT_FLIP) ? STEP_NB4 : STEP_NB3;

	// read address for the current step
	always_comb begin
		rd_row = row_q;
		rd_col = col_q;
		if (act_q == ACT_FLIP) begin
			case (step_q)
				STEP_SELF: ;
				STEP_NB1:  rd_row = wrap_inc(row_q);
				STEP_NB2:  rd_row = wrap_dec(row_q);
				STEP_NB3:  rd_col = wrap_inc(col_q);
				STEP_NB4:  rd_col = wrap_dec(col_q);
				default:   ;
			endcase
		end else begin
			case (step_q)
				STEP_SELF: ;
				STEP_NB1:  rd_col = wrap_inc(col_q);
				STEP_NB2:  rd_row = wrap_inc(row_q);
				STEP_NB3:  rd_row = wrap_add(row_q, dist_q);
				default:   ;
			endcase
		end
	end

	assign raddr = ADDR_W'(rd_row) * SIDE_A + ADDR_W'(rd_col);
	assign waddr = ADDR_W'(row_q) * SIDE_A + ADDR_W'(col_q);

	// metropolis decision
	always_comb begin
		de_c = s_q ? {nb_q, 1'b0} : DE_W'(0) - {nb_q, 1'b0};
		if (de_c[DE_W-1] || (de_c == '0)) begin
			flip_c = 1'b1;
		end else if (de_c == DE_FOUR) begin
			flip_c = draw_q < thr_four_q;
		end else begin
			flip_c = draw_q < thr_eight_q;
		end
	end

	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_DECIDE) && flip_c);
	assign ram_wdata = (state_q == ST_CLEAR) ? 1'b1 : !s_q;
	assign same_spin = (s_q == ram_rdata);

	imlat_ram #(
		.WIDTH (1),
		.DEPTH (SIDE * SIDE)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_four_q  <= '0;
			thr_eight_q <= '0;
			corr_dist_q <= CORR_DIST_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_THR_FOUR:  thr_four_q  <= cfg.data;
				REG_THR_EIGHT: thr_eight_q <= cfg.data;
				REG_CORR_DIST: corr_dist_q <= cfg.data[DIST_W-1:0];
				default:       ;
			endcase
		end
	end

	// accumulate read beats in the cycle after their address is issued
	always_ff @(posedge clk) begin
		if (req_fire) begin
			nb_q     <= '0;
			sum_q    <= '0;
			energy_q <= '0;
			corr_q   <= '0;
		end else if (tag_s1.valid) begin
			if (tag_s1.step == STEP_SELF) begin
				s_q <= ram_rdata;
				if (act_q == ACT_MEASURE) begin
					sum_q <= ram_rdata ? sum_q + SUM_W'(1) : sum_q - SUM_W'(1);
				end
			end else if (act_q == ACT_FLIP) begin
				nb_q <= ram_rdata ? nb_q + 4'sd1 : nb_q - 4'sd1;
			end else if (tag_s1.step == STEP_NB3) begin
				corr_q <= same_spin ? corr_q + CORR_W'(1) : corr_q - CORR_W'(1);
			end else begin
				energy_q <= same_spin ? energy_q - ENERGY_W'(1) : energy_q + ENERGY_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			draw_q <= req.uniform_draw;
			flip_q <= 1'b0;
			de_q   <= '0;
		end else if (state_q == ST_DECIDE) begin
			flip_q <= flip_c;
			de_q   <= de_c;
		end
		if ((state_q == ST_DONE) && slot_free) begin
			out_flipped_q <= flip_q;
			out_de_q      <= de_q;
			out_sum_q     <= sum_q;
			out_energy_q  <= energy_q;
			out_corr_q    <= corr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			act_q       <= ACT_FLIP;
			init_q      <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			dist_q      <= '0;
			step_q      <= STEP_SELF;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			tag_s1.valid <= (state_q == ST_READ);
			tag_s1.step  <= step_q;
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sweep_last) begin
						row_q   <= '0;
						col_q   <= '0;
						state_q <= init_q ? ST_DONE : ST_IDLE;
					end else if (col_q == IDX_LAST) begin
						col_q <= '0;
						row_q <= row_q + IDX_W'(1);
					end else begin
						col_q <= col_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						act_q  <= req.action;
						init_q <= (req.action == ACT_INIT);
						step_q <= STEP_SELF;
						dist_q <= mod_side(corr_dist_q);
						case (req.action)
							ACT_FLIP: begin
								row_q   <= mod_side(req.site_row);
								col_q   <= mod_side(req.site_col);
								state_q <= ST_READ;
							end
							ACT_MEASURE: begin
								row_q   <= '0;
								col_q   <= '0;
								state_q <= ST_READ;
							end
							ACT_INIT: begin
								row_q   <= '0;
								col_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_READ: begin
					if (step_q == step_last) begin
						step_q <= STEP_SELF;
						if ((act_q == ACT_FLIP) || sweep_last) begin
							state_q <= ST_DRAIN;
						end else if (col_q == IDX_LAST) begin
							col_q <= '0;
							row_q <= row_q + IDX_W'(1);
						end else begin
							col_q <= col_q + IDX_W'(1);
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= (act_q == ACT_FLIP) ? ST_DECIDE : ST_DONE;
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.flipped         = out_flipped_q;
	assign rsp.delta_energy    = out_de_q;
	assign rsp.spin_sum        = out_sum_q;
	assign rsp.lattice_energy  = out_energy_q;
	assign rsp.correlation_sum = out_corr_q;

	a_flip_has_no_sums: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_flipped_q |->
			(out_sum_q == '0) && (out_energy_q == '0) && (out_corr_q == '0))
		else $error("flip result carries measure fields");

	a_de_multiple_of_four: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_de_q[1:0] == 2'b00))
		else $error("delta energy not a multiple of four");

	a_read_beat_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid |-> ($past(state_q) == ST_READ))
		else $error("read beat without a read issue");

	a_done_waits_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !slot_free |=> (state_q == ST_DONE) && out_valid_q)
		else $error("result finished while output register busy");

endmodule

`default_nettype wire

[verif/tb_ising_metropolis_lattice_core.sv]
// ---------------------------------------------------------------------------
// tb_ising_metropolis_lattice_core
// Self-checking bench for the Metropolis lattice core: a scoreboard class
// keeps its own copy of the spin lattice and thresholds, predicts every
// result beat in order and compares it field by field against the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ising_metropolis_lattice_core
	import imlat_pkg::*;
;

	localparam int L = SIDE_DEFAULT;
	localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_PCT = 38;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 240;
	localparam int TAIL_CYCLES = 1100;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [SITE_W-1:0]   site_row;
		logic [SITE_W-1:0]   site_col;
		logic [DRAW_W-1:0]   uniform_draw;
	} flip_request_t;

	typedef struct {
		logic                       flipped;
		logic signed [DE_W-1:0]     delta_energy;
		logic signed [SUM_W-1:0]    spin_sum;
		logic signed [ENERGY_W-1:0] lattice_energy;
		logic signed [CORR_W-1:0]   correlation_sum;
	} lattice_result_t;

	class metropolis_scoreboard;
		bit                spin_up [L*L];
		logic [DRAW_W-1:0] thr_four;
		logic [DRAW_W-1:0] thr_eight;
		logic [DIST_W-1:0] row_offset;
		lattice_result_t   pending_results [$];
		int                errors;

		function new();
			spin_up = '{default: 1'b1};
			thr_four = '0;
			thr_eight = '0;
			row_offset = CORR_DIST_RESET;
			errors = 0;
		endfunction

		function int spin(int r, int c);
			return spin_up[(r % L) * L + (c % L)] ? 1 : -1;
		endfunction

		function void apply_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_THR_FOUR: thr_four = data;
				REG_THR_EIGHT: thr_eight = data;
				REG_CORR_DIST: row_offset = data[DIST_W-1:0];
				default: ;
			endcase
		endfunction

		function void apply_request(flip_request_t it);
			lattice_result_t o;
			int r, c, s, nb, de, d, sum, bonds, corr;
			bit take;
			o = '{default: '0};
			case (it.action)
				ACT_FLIP: begin
					r = it.site_row % L;
					c = it.site_col % L;
					s = spin(r, c);
					nb = spin(r + 1, c) + spin(r + L - 1, c) + spin(r, c + 1) + spin(r, c + L - 1);
					de = 2 * s * nb;
					if (de <= 0)
						take = 1'b1;
					else if (de == 4)
						take = it.uniform_draw < thr_four;
					else
						take = it.uniform_draw < thr_eight;
					if (take)
						spin_up[r * L + c] = !spin_up[r * L + c];
					o.flipped = take;
					o.delta_energy = DE_W'(de);
				end
				ACT_MEASURE: begin
					d = row_offset % L;
					sum = 0;
					bonds = 0;
					corr = 0;
					for (int i = 0; i < L; i++) begin
						for (int j = 0; j < L; j++) begin
							s = spin(i, j);
							sum += s;
							bonds += s * (spin(i, j + 1) + spin(i + 1, j));
							corr += s * spin(i + d, j);
						end
					end
					o.spin_sum = SUM_W'(sum);
					o.lattice_energy = ENERGY_W'(-bonds);
					o.correlation_sum = CORR_W'(corr);
				end
				ACT_INIT: spin_up = '{default: 1'b1};
				default: ;
			endcase
			pending_results.push_back(o);
		endfunction

		function void compare_field(string name, logic signed [15:0] want,
			logic signed [15:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(lattice_result_t got);
			lattice_result_t want;
			if (pending_results.size() == 0) begin
				$error("result beat with no request outstanding");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("flipped", want.flipped, got.flipped);
			compare_field("delta_energy", want.delta_energy, got.delta_energy);
			compare_field("spin_sum", want.spin_sum, got.spin_sum);
			compare_field("lattice_energy", want.lattice_energy, got.lattice_energy);
			compare_field("correlation_sum", want.correlation_sum, got.correlation_sum);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	bit   hold_rsp;
	logic [DRAW_W-1:0] thr4_set;
	logic [DRAW_W-1:0] thr8_set;

	imlat_req_if req_ch ();
	imlat_rsp_if rsp_ch ();
	imlat_cfg_if cfg_ch ();

	metropolis_scoreboard sb = new;

	ising_metropolis_lattice_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// all beats are sampled here so that notes and checks keep edge order
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.apply_register(cfg_ch.addr, cfg_ch.data);
			if (req_ch.valid && req_ch.ready)
				sb.apply_request('{req_ch.action, req_ch.site_row, req_ch.site_col,
					req_ch.uniform_draw});
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result('{rsp_ch.flipped, rsp_ch.delta_energy, rsp_ch.spin_sum,
					rsp_ch.lattice_energy, rsp_ch.correlation_sum});
		end
	end

	// result side: random backpressure, one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end
			rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic flip_request_t req_beat(logic [ACTION_W-1:0] action,
		logic [SITE_W-1:0] row, logic [SITE_W-1:0] col, logic [DRAW_W-1:0] draw);
		flip_request_t it;
		it.action = action;
		it.site_row = row;
		it.site_col = col;
		it.uniform_draw = draw;
		return it;
	endfunction

	task automatic send_item(flip_request_t it);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= it.action;
		req_ch.site_row <= it.site_row;
		req_ch.site_col <= it.site_col;
		req_ch.uniform_draw <= it.uniform_draw;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic apply_settings(logic [DRAW_W-1:0] four, logic [DRAW_W-1:0] eight,
		logic [CFG_DATA_W-1:0] dist_word, bit poke_unused);
		wait_drained();
		write_reg(REG_THR_FOUR, four);
		write_reg(REG_THR_EIGHT, eight);
		write_reg(REG_CORR_DIST, dist_word);
		if (poke_unused)
			write_reg(REG_UNUSED, $urandom);
		cfg_ch.valid <= 1'b0;
		thr4_set = four;
		thr8_set = eight;
	endtask

	task automatic run_phase(int count, bit clustered);
		flip_request_t it;
		int roll;
		logic [SITE_W-1:0] base_r, base_c;
		base_r = SITE_W'($urandom_range(15));
		base_c = SITE_W'($urandom_range(15));
		for (int i = 0; i < count; i++) begin
			// move the hot spot now and then so domains form in several places
			if (i % 60 == 59) begin
				base_r = SITE_W'($urandom_range(15));
				base_c = SITE_W'($urandom_range(15));
			end
			roll = $urandom_range(199);
			if (roll < 14)
				it.action = ACT_MEASURE;
			else if (roll < 16)
				it.action = ACT_INIT;
			else if (roll < 19)
				it.action = ACT_UNDEF;
			else
				it.action = ACT_FLIP;
			it.site_row = clustered ? base_r + SITE_W'($urandom_range(3))
				: SITE_W'($urandom_range(15));
			it.site_col = clustered ? base_c + SITE_W'($urandom_range(3))
				: SITE_W'($urandom_range(15));
			// draws right at and just below the thresholds hit the strict compare
			case ($urandom_range(9))
				0: it.uniform_draw = thr4_set;
				1: it.uniform_draw = thr4_set - 1;
				2: it.uniform_draw = thr8_set;
				3: it.uniform_draw = thr8_set - 1;
				default: it.uniform_draw = $urandom;
			endcase
			send_item(it);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_FLIP;
		req_ch.site_row <= '0;
		req_ch.site_col <= '0;
		req_ch.uniform_draw <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= REG_THR_FOUR;
		cfg_ch.data <= '0;
		thr4_set = '0;
		thr8_set = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: default distance, zero thresholds
		send_item(req_beat(ACT_MEASURE, 4'd0, 4'd0, 32'd0));
		send_item(req_beat(ACT_FLIP, 4'd3, 4'd3, 32'd0));

		apply_settings(32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 1'b0);
		send_item(req_beat(ACT_FLIP, 4'd0, 4'd0, 32'h0000_0000));
		send_item(req_beat(ACT_FLIP, 4'd0, 4'd0, 32'hFFFF_FFFF));
		send_item(req_beat(ACT_FLIP, 4'd0, 4'd0, 32'hFFFF_FFFF));
		send_item(req_beat(ACT_FLIP, 4'd0, 4'd0, 32'h7FFF_FFFF));
		send_item(req_beat(ACT_FLIP, 4'd0, 4'd1, 32'hFFFF_FFFE));
		send_item(req_beat(ACT_FLIP, 4'd15, 4'd15, 32'h8000_0000));
		send_item(req_beat(ACT_FLIP, 4'd15, 4'd0, 32'h0000_0000));
		send_item(req_beat(ACT_FLIP, 4'd0, 4'd15, 32'h0000_0000));
		send_item(req_beat(ACT_MEASURE, 4'd15, 4'd15, 32'hFFFF_FFFF));
		send_item(req_beat(ACT_UNDEF, 4'd15, 4'd15, 32'hFFFF_FFFF));
		send_item(req_beat(ACT_MEASURE, 4'd0, 4'd0, 32'd0));
		send_item(req_beat(ACT_INIT, 4'd9, 4'd6, 32'h5A5A_A5A5));
		send_item(req_beat(ACT_MEASURE, 4'd0, 4'd0, 32'd0));
		send_item(req_beat(ACT_FLIP, 4'd15, 4'd15, 32'hFFFF_FFFF));
		send_item(req_beat(ACT_MEASURE, 4'd0, 4'd0, 32'd0));

		// upper data bits of the distance write must be dropped
		apply_settings(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
		run_phase(PHASE_ITEMS, 1'b0);

		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1);
		steady = 1'b1;
		run_phase(PHASE_ITEMS, 1'b1);
		steady = 1'b0;

		apply_settings($urandom, $urandom, $urandom, 1'b0);
		hold_rsp = 1'b1;
		run_phase(PHASE_ITEMS, 1'b0);

		apply_settings($urandom, 32'd0, 32'd8, 1'b0);
		run_phase(PHASE_ITEMS, 1'b1);

		apply_settings(32'hFFFF_FFFF, 32'h4000_0000, 32'd1, 1'b0);
		run_phase(PHASE_ITEMS, 1'b1);

		apply_settings($urandom, $urandom, $urandom, 1'b1);
		run_phase(PHASE_ITEMS, 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
rtl/imlat_pkg.sv
rtl/imlat_if.sv
rtl/imlat_ram.sv
rtl/ising_metropolis_lattice_core.sv
verif/tb_ising_metropolis_lattice_core.sv
